@@ sv/cbpm_pkg.sv @@
package cbpm_pkg;
  localparam int Frames = 16;
  localparam int FrameW = $clog2(Frames);
  localparam int CntW = $clog2(Frames + 2);

  localparam logic [1:0] MODE_PIN = 2'd0;
  localparam logic [1:0] MODE_UNPIN = 2'd1;
  localparam logic [1:0] MODE_ALLOC = 2'd2;
  localparam logic [1:0] MODE_DISPOSE = 2'd3;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_LOADED = 3'd1;
  localparam logic [2:0] ST_EXCEEDED = 3'd2;
  localparam logic [2:0] ST_NOT_PINNED = 3'd3;
  localparam logic [2:0] ST_PAGE_PINNED = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_CAPTURE = 3'd1;
  localparam logic [2:0] OP_LOOKUP = 3'd2;
  localparam logic [2:0] OP_SWEEP = 3'd3;
  localparam logic [2:0] OP_FAIL = 3'd4;

  typedef struct packed {
    logic [2:0] op;
  } cbpm_cmd_t;

  typedef struct packed {
    logic sweep_needed;
    logic sweep_done;
    logic sweep_giveup;
  } cbpm_stat_t;
endpackage

@@ sv/cbpm_ctrl.sv @@
module cbpm_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cbpm_pkg::cbpm_cmd_t cmd,
  input  cbpm_pkg::cbpm_stat_t stat
);
  import cbpm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state, state_next;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_CAPTURE;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.op = OP_LOOKUP;
        state_next = stat.sweep_needed ? S_SWEEP : S_OUT;
      end
      S_SWEEP: begin
        if (stat.sweep_giveup) begin
          cmd.op = OP_FAIL;
          state_next = S_OUT;
        end else begin
          cmd.op = OP_SWEEP;
          if (stat.sweep_done) state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept while result pending");
endmodule

@@ sv/cbpm_dp.sv @@
module cbpm_dp (
  input  logic clk,
  input  logic rst,
  input  cbpm_pkg::cbpm_cmd_t cmd,
  output cbpm_pkg::cbpm_stat_t stat,
  input  logic [1:0] mode,
  input  logic [7:0] file_id,
  input  logic [31:0] page_no,
  input  logic set_dirty,
  output logic [2:0] status,
  output logic [3:0] frame,
  output logic writeback,
  output logic [7:0] victim_file,
  output logic [31:0] victim_page
);
  import cbpm_pkg::*;

  logic [Frames-1:0] vld, refd, modf;
  logic [7:0] pins [Frames];
  logic [7:0] ftag [Frames];
  logic [31:0] ptag [Frames];
  logic [FrameW-1:0] hand;
  logic [CntW-1:0] pinned;

  logic [1:0] r_mode;
  logic [7:0] r_file;
  logic [31:0] r_page;
  logic r_dirty;

  logic hit;
  logic [FrameW-1:0] hit_idx;
  logic [FrameW-1:0] h;

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = Frames - 1; i >= 0; i--) begin
      if (vld[i] && ftag[i] == r_file && ptag[i] == r_page) begin
        hit = 1'b1;
        hit_idx = FrameW'(i);
      end
    end
  end

  assign h = (hand == FrameW'(Frames - 1)) ? '0 : hand + FrameW'(1);
  assign stat.sweep_needed = (r_mode == MODE_ALLOC) || (r_mode == MODE_PIN && !hit);
  assign stat.sweep_giveup = (pinned > CntW'(Frames));
  assign stat.sweep_done = !vld[h] || (!refd[h] && pins[h] == 8'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      refd <= '0;
      modf <= '0;
      for (int i = 0; i < Frames; i++) pins[i] <= '0;
      hand <= FrameW'(Frames - 1);
      pinned <= '0;
    end else begin
      case (cmd.op)
        OP_CAPTURE: begin
          r_mode <= mode;
          r_file <= file_id;
          r_page <= page_no;
          r_dirty <= set_dirty;
          pinned <= '0;
          writeback <= 1'b0;
          victim_file <= '0;
          victim_page <= '0;
        end
        OP_LOOKUP: begin
          frame <= '0;
          status <= ST_HIT;
          if (r_mode == MODE_PIN && hit) begin
            refd[hit_idx] <= 1'b1;
            if (pins[hit_idx] != 8'hFF) pins[hit_idx] <= pins[hit_idx] + 8'd1;
            frame <= 4'(hit_idx);
          end else if (r_mode == MODE_UNPIN) begin
            if (!hit) status <= ST_NOT_FOUND;
            else if (pins[hit_idx] == 8'd0) status <= ST_NOT_PINNED;
            else begin
              if (r_dirty) modf[hit_idx] <= 1'b1;
              pins[hit_idx] <= pins[hit_idx] - 8'd1;
              frame <= 4'(hit_idx);
            end
          end else if (r_mode == MODE_DISPOSE) begin
            if (!hit) status <= ST_NOT_FOUND;
            else if (pins[hit_idx] != 8'd0) status <= ST_PAGE_PINNED;
            else begin
              vld[hit_idx] <= 1'b0;
              refd[hit_idx] <= 1'b0;
              modf[hit_idx] <= 1'b0;
              frame <= 4'(hit_idx);
            end
          end
        end
        OP_SWEEP: begin
          hand <= h;
          if (!vld[h] || (!refd[h] && pins[h] == 8'd0)) begin
            if (vld[h] && modf[h]) begin
              writeback <= 1'b1;
              victim_file <= ftag[h];
              victim_page <= ptag[h];
            end
            vld[h] <= 1'b1;
            refd[h] <= 1'b1;
            pins[h] <= 8'd1;
            modf[h] <= 1'b0;
            ftag[h] <= r_file;
            ptag[h] <= r_page;
            status <= ST_LOADED;
            frame <= 4'(h);
          end else if (refd[h]) begin
            refd[h] <= 1'b0;
          end else begin
            pinned <= pinned + CntW'(1);
          end
        end
        OP_FAIL: begin
          status <= ST_EXCEEDED;
          frame <= '0;
        end
        default: ;
      endcase
    end
  end

  a_hand_range: assert property (@(posedge clk) disable iff (rst)
    hand <= FrameW'(Frames - 1)) else $error("hand out of range");
  a_load_pin: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SWEEP && stat.sweep_done) |=> (pins[$past(h)] == 8'd1))
    else $error("loaded frame not pinned once");
  a_wb_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_CAPTURE) |=> !writeback) else $error("stale writeback");
endmodule

@@ sv/clock_buffer_pool_manager.sv @@
// Clock-replacement buffer pool manager over 16 frame descriptors. One request
// at a time: a request is captured, its tag is matched against all frames at
// once in the lookup state, and the result is offered from the output state.
// Unpin, dispose and pin hits go straight from lookup to output; a pin miss or
// an allocate runs the clock sweep in between, one frame per cycle. The sweep
// visits up to 2*16+1 frames before it gives up. in_stall stays high until the
// result has been taken.
module clock_buffer_pool_manager (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] file_id,
  input  logic [31:0] page_no,
  input  logic set_dirty,
  output logic out_valid,
  input  logic out_stall,
  output logic [2:0] status,
  output logic [3:0] frame,
  output logic writeback,
  output logic [7:0] victim_file,
  output logic [31:0] victim_page
);
  import cbpm_pkg::*;

  cbpm_cmd_t cmd;
  cbpm_stat_t stat;

  cbpm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  cbpm_dp u_dp (
    .clk, .rst, .cmd, .stat, .mode, .file_id, .page_no, .set_dirty,
    .status, .frame, .writeback, .victim_file, .victim_page
  );
endmodule

@@ verif/clock_buffer_pool_manager_chk.sv @@
module clock_buffer_pool_manager_chk (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] file_id,
  input  logic [31:0] page_no,
  input  logic set_dirty,
  input  logic out_valid,
  input  logic out_stall,
  input  logic [2:0] status,
  input  logic [3:0] frame,
  input  logic writeback,
  input  logic [7:0] victim_file,
  input  logic [31:0] victim_page,
  output int errors,
  output int pending
);
  import cbpm_pkg::*;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] frame;
    logic wb;
    logic [7:0] vfile;
    logic [31:0] vpage;
  } pool_result_t;

  logic fv [Frames];
  logic fref [Frames];
  logic [7:0] fpins [Frames];
  logic fmod [Frames];
  logic [7:0] ffile [Frames];
  logic [31:0] fpage [Frames];
  logic [3:0] hand;
  pool_result_t results_q[$];

  assign pending = results_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic void drop_frame(int i);
    fv[i] = 1'b0; fref[i] = 1'b0; fpins[i] = '0; fmod[i] = 1'b0;
  endfunction

  function automatic int pick_victim(ref pool_result_t r);
    int pinned;
    int h;
    pinned = 0;
    while (pinned <= Frames) begin
      hand = (int'(hand) >= Frames - 1) ? 4'd0 : hand + 4'd1;
      h = hand;
      if (!fv[h]) return h;
      if (fref[h]) begin
        fref[h] = 1'b0;
        continue;
      end
      if (fpins[h] == 0) begin
        if (fmod[h]) begin
          r.wb = 1'b1; r.vfile = ffile[h]; r.vpage = fpage[h];
        end
        drop_frame(h);
        return h;
      end
      pinned++;
    end
    return -1;
  endfunction

  function automatic pool_result_t serve(logic [1:0] m, logic [7:0] f, logic [31:0] p,
                                         logic d);
    pool_result_t r;
    int i;
    int n;
    r = '0;
    i = -1;
    for (int k = Frames - 1; k >= 0; k--)
      if (fv[k] && ffile[k] == f && fpage[k] == p) i = k;
    if (m == MODE_PIN && i >= 0) begin
      fref[i] = 1'b1;
      if (fpins[i] != 8'hff) fpins[i]++;
      r.status = ST_HIT; r.frame = 4'(i);
    end else if (m == MODE_PIN || m == MODE_ALLOC) begin
      n = pick_victim(r);
      if (n < 0) r.status = ST_EXCEEDED;
      else begin
        fv[n] = 1'b1; fref[n] = 1'b1; fpins[n] = 8'd1; fmod[n] = 1'b0;
        ffile[n] = f; fpage[n] = p;
        r.status = ST_LOADED; r.frame = 4'(n);
      end
    end else if (m == MODE_UNPIN) begin
      if (i < 0) r.status = ST_NOT_FOUND;
      else if (fpins[i] == 0) r.status = ST_NOT_PINNED;
      else begin
        if (d) fmod[i] = 1'b1;
        fpins[i]--;
        r.status = ST_HIT; r.frame = 4'(i);
      end
    end else begin
      if (i < 0) r.status = ST_NOT_FOUND;
      else if (fpins[i] > 0) r.status = ST_PAGE_PINNED;
      else begin
        drop_frame(i);
        r.status = ST_HIT; r.frame = 4'(i);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pool_result_t e;
    if (rst) begin
      for (int k = 0; k < Frames; k++) begin
        drop_frame(k); ffile[k] = '0; fpage[k] = '0;
      end
      hand = 4'(Frames - 1);
      results_q.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall)
        results_q.push_back(serve(mode, file_id, page_no, set_dirty));
      if (out_valid && !out_stall) begin
        if (results_q.size() == 0) begin
          report("unexpected result", 64'(status), 64'd0);
        end else begin
          e = results_q.pop_front();
          if (status !== e.status) report("status", 64'(status), 64'(e.status));
          if (frame !== e.frame) report("frame", 64'(frame), 64'(e.frame));
          if (writeback !== e.wb) report("writeback", 64'(writeback), 64'(e.wb));
          if (victim_file !== e.vfile)
            report("victim_file", 64'(victim_file), 64'(e.vfile));
          if (victim_page !== e.vpage)
            report("victim_page", 64'(victim_page), 64'(e.vpage));
        end
      end
    end
  end
endmodule

@@ verif/clock_buffer_pool_manager_tb.sv @@
module clock_buffer_pool_manager_tb;
  import cbpm_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] mode = MODE_PIN;
  logic [7:0] file_id = 0;
  logic [31:0] page_no = 0;
  logic set_dirty = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] status;
  logic [3:0] frame;
  logic writeback;
  logic [7:0] victim_file;
  logic [31:0] victim_page;
  int errors;
  int pending;
  bit hold_rx = 0;
  bit long_hold = 0;
  int rx_gap = 0;

  logic [7:0] tag_file [8];
  logic [31:0] tag_page [8];

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  clock_buffer_pool_manager u_dut (.*);

  clock_buffer_pool_manager_chk u_chk (.*);

  task automatic send(logic [1:0] m, logic [7:0] f, logic [31:0] p, logic d);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; mode <= m; file_id <= f; page_no <= p; set_dirty <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_pool(logic [1:0] m);
    int k;
    k = $urandom_range(0, 7);
    send(m, tag_file[k], tag_page[k], 1'($urandom_range(0, 1)));
  endtask

  // per-result wait, drawn when a result is taken
  always @(posedge clk) begin
    if (long_hold) out_stall <= 1;
    else if (out_valid && !out_stall) begin
      rx_gap = hold_rx ? 0 : $urandom_range(0, 12);
      out_stall <= (rx_gap != 0);
    end else if (rx_gap > 0) begin
      rx_gap = rx_gap - 1;
      out_stall <= (rx_gap != 0);
    end else out_stall <= 0;
  end

  initial begin
    int n;
    for (int k = 0; k < 8; k++) begin
      tag_file[k] = 8'($urandom); tag_page[k] = $urandom;
    end
    tag_file[0] = 8'h00; tag_page[0] = 32'h0;
    tag_file[1] = 8'hff; tag_page[1] = 32'hffff_ffff;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send(MODE_UNPIN, 8'h00, 32'h0, 1'b0);
    send(MODE_DISPOSE, 8'hff, 32'hffff_ffff, 1'b0);
    send(MODE_PIN, 8'h00, 32'h0, 1'b0);
    send(MODE_PIN, 8'h00, 32'h0, 1'b0);
    send(MODE_ALLOC, 8'h00, 32'h0, 1'b0);
    send(MODE_DISPOSE, 8'h00, 32'h0, 1'b0);
    send(MODE_UNPIN, 8'h00, 32'h0, 1'b1);
    send(MODE_UNPIN, 8'h00, 32'h0, 1'b1);
    send(MODE_UNPIN, 8'h00, 32'h0, 1'b0);
    send(MODE_UNPIN, 8'h00, 32'h0, 1'b0);
    send(MODE_DISPOSE, 8'h00, 32'h0, 1'b0);
    for (int k = 0; k < 17; k++) send(MODE_ALLOC, 8'hff, 32'hffff_ffff - k, 1'b0);
    for (int k = 0; k < 300; k++) send(MODE_PIN, 8'hff, 32'hffff_ffff, 1'b0);
    for (int k = 0; k < 10; k++) send(MODE_UNPIN, 8'hff, 32'hffff_fff0 + k, 1'b1);
    for (int k = 0; k < 6; k++) send(MODE_ALLOC, 8'h5a, 32'(k), 1'b0);

    n = 0;
    while (n < 900) begin
      if (n == 400) begin
        long_hold = 1;
        fork
          begin
            repeat (300) @(posedge clk);
            long_hold = 0;
          end
        join_none
      end
      if (n == 700) begin
        in_valid <= 0;
        wait (pending == 0);
        @(posedge clk);
      end
      if (n % 97 == 0) hold_rx = !hold_rx;
      case ($urandom_range(0, 9))
        0, 1, 2: send_pool(MODE_PIN);
        3, 4: send_pool(MODE_UNPIN);
        5: send_pool(MODE_ALLOC);
        6: send_pool(MODE_DISPOSE);
        7: send(2'($urandom_range(0, 3)), 8'($urandom), $urandom,
                1'($urandom_range(0, 1)));
        default: send(MODE_ALLOC, 8'($urandom), $urandom, 1'b0);
      endcase
      n++;
    end
    in_valid <= 0;
    hold_rx = 0;
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("[clock_buffer_pool_manager] OK");
    else $display("[clock_buffer_pool_manager] ERROR");
    $finish;
  end

  initial begin
    #20000000;
    $display("[clock_buffer_pool_manager] ERROR");
    $finish;
  end
endmodule
